@@ hdl/fc4_pkg.sv @@
// shared types and constants for the eight-lane fletcher-4 checksum
// no dependencies; used by fc4_merge and the top level

package fc4_pkg;

   localparam int LANES  = 8;
   localparam int WORD_W = 32;
   localparam int SUM_W  = 64;
   localparam int WT_W   = 10;

   // merge weights per lane
   localparam logic [WT_W-1:0] C_WT_A [LANES] = '{10'd0, 10'd0, 10'd1, 10'd3,
                                                  10'd6, 10'd10, 10'd15, 10'd21};
   localparam logic [WT_W-1:0] C_WT_B [LANES] = '{10'd28, 10'd36, 10'd44, 10'd52,
                                                  10'd60, 10'd68, 10'd76, 10'd84};
   localparam logic [WT_W-1:0] D_WT_A [LANES] = '{10'd0, 10'd0, 10'd0, 10'd1,
                                                  10'd4, 10'd10, 10'd20, 10'd35};
   localparam logic [WT_W-1:0] D_WT_B [LANES] = '{10'd56, 10'd84, 10'd120, 10'd164,
                                                  10'd216, 10'd276, 10'd344, 10'd420};
   localparam logic [WT_W-1:0] D_WT_C [LANES] = '{10'd448, 10'd512, 10'd576, 10'd640,
                                                  10'd704, 10'd768, 10'd832, 10'd896};

   typedef struct packed {
      logic [WORD_W-1:0] word_0;
      logic [WORD_W-1:0] word_1;
      logic [WORD_W-1:0] word_2;
      logic [WORD_W-1:0] word_3;
      logic [WORD_W-1:0] word_4;
      logic [WORD_W-1:0] word_5;
      logic [WORD_W-1:0] word_6;
      logic [WORD_W-1:0] word_7;
      logic              last_block;
   } req_type;

   typedef struct packed {
      logic [SUM_W-1:0] sum_a;
      logic [SUM_W-1:0] sum_b;
      logic [SUM_W-1:0] sum_c;
      logic [SUM_W-1:0] sum_d;
   } rsp_type;

   // four running sums for every lane
   typedef struct packed {
      logic [LANES-1:0][SUM_W-1:0] first;
      logic [LANES-1:0][SUM_W-1:0] second;
      logic [LANES-1:0][SUM_W-1:0] third;
      logic [LANES-1:0][SUM_W-1:0] fourth;
   } lanes_type;

   // two partial totals per checksum word
   typedef struct packed {
      logic [1:0][SUM_W-1:0] a;
      logic [1:0][SUM_W-1:0] b;
      logic [1:0][SUM_W-1:0] c;
      logic [1:0][SUM_W-1:0] d;
   } part_type;

endpackage

@@ hdl/fletcher4_eight_lane_checksum_top.sv @@
// top level of the eight-lane fletcher-4 checksum: input register, lane sums
// depends on fc4_pkg and fc4_merge
// throughput: one block of eight words per cycle, set by the lane add chain,
// stalled only while a last block waits for the merge to accept it
// reset: clears the lane sums, byte_swap and all stage valid flags

module fletcher4_eight_lane_checksum_top (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  fc4_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output fc4_pkg::rsp_type rsp_data,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic             csr_data
);

   logic                                     in_vld_ff;
   fc4_pkg::req_type                         req_ff;
   logic                                     byte_swap_ff;
   fc4_pkg::lanes_type                       lanes_ff, lanes_upd;
   logic [fc4_pkg::LANES-1:0][fc4_pkg::WORD_W-1:0] words;
   logic                                     consume, snap_valid, snap_ready;

   function automatic logic [fc4_pkg::WORD_W-1:0] swap32(
      input logic [fc4_pkg::WORD_W-1:0] w
   );
      swap32 = {w[7:0], w[15:8], w[23:16], w[31:24]};
   endfunction

   // configuration register
   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         byte_swap_ff <= 1'b0;
      end else if (csr_valid) begin
         byte_swap_ff <= csr_data;
      end
   end

   // input register
   assign snap_valid = in_vld_ff && req_ff.last_block;
   assign consume    = in_vld_ff && (!req_ff.last_block || snap_ready);
   assign req_ready  = !in_vld_ff || consume;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else if (req_ready) begin
         in_vld_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready) req_ff <= req_data;
   end

   // lane words, optionally byte reversed
   always_comb begin
      words = {req_ff.word_7, req_ff.word_6, req_ff.word_5, req_ff.word_4,
               req_ff.word_3, req_ff.word_2, req_ff.word_1, req_ff.word_0};
      if (byte_swap_ff) begin
         for (int i = 0; i < fc4_pkg::LANES; i++) begin
            words[i] = swap32(words[i]);
         end
      end
   end

   // running sum chain per lane
   always_comb begin
      for (int i = 0; i < fc4_pkg::LANES; i++) begin
         lanes_upd.first[i]  = lanes_ff.first[i]  + fc4_pkg::SUM_W'(words[i]);
         lanes_upd.second[i] = lanes_ff.second[i] + lanes_upd.first[i];
         lanes_upd.third[i]  = lanes_ff.third[i]  + lanes_upd.second[i];
         lanes_upd.fourth[i] = lanes_ff.fourth[i] + lanes_upd.third[i];
      end
   end

   // lane state, cleared once a last block is handed to the merge
   always_ff @(posedge clock) begin
      if (reset) begin
         lanes_ff <= '0;
      end else if (consume) begin
         if (req_ff.last_block) begin
            lanes_ff <= '0;
         end else begin
            lanes_ff <= lanes_upd;
         end
      end
   end

   fc4_merge u_merge (
      .clock      (clock),
      .reset      (reset),
      .snap_valid (snap_valid),
      .snap_ready (snap_ready),
      .snap_data  (lanes_upd),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data)
   );

endmodule

@@ hdl/fc4_merge.sv @@
// lane merge pipeline: weights the eight lane sums and totals them
// depends on fc4_pkg

module fc4_merge (
   input  logic               clock,
   input  logic               reset,
   input  logic               snap_valid,
   output logic               snap_ready,
   input  fc4_pkg::lanes_type snap_data,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output fc4_pkg::rsp_type   rsp_data
);

   logic               snap_vld_ff, term_vld_ff, part_vld_ff, rsp_vld_ff;
   fc4_pkg::lanes_type snap_ff;
   fc4_pkg::lanes_type term_ff, term_in;
   fc4_pkg::part_type  part_ff, part_in;
   fc4_pkg::rsp_type   rsp_ff, rsp_in;
   logic               rsp_en, part_en, term_en, snap_en;

   // stage advance chain
   assign rsp_en  = !rsp_vld_ff  || rsp_ready;
   assign part_en = !part_vld_ff || rsp_en;
   assign term_en = !term_vld_ff || part_en;
   assign snap_en = !snap_vld_ff || term_en;
   assign snap_ready = snap_en;

   // per-lane weighted terms
   always_comb begin
      for (int i = 0; i < fc4_pkg::LANES; i++) begin
         term_in.first[i]  = snap_ff.first[i];
         term_in.second[i] = (snap_ff.second[i] << 3)
                           - (snap_ff.first[i] * fc4_pkg::SUM_W'(i));
         term_in.third[i]  = (snap_ff.third[i] << 6)
                           - (snap_ff.second[i] * fc4_pkg::SUM_W'(fc4_pkg::C_WT_B[i]))
                           + (snap_ff.first[i]  * fc4_pkg::SUM_W'(fc4_pkg::C_WT_A[i]));
         term_in.fourth[i] = (snap_ff.fourth[i] << 9)
                           - (snap_ff.third[i]  * fc4_pkg::SUM_W'(fc4_pkg::D_WT_C[i]))
                           + (snap_ff.second[i] * fc4_pkg::SUM_W'(fc4_pkg::D_WT_B[i]))
                           - (snap_ff.first[i]  * fc4_pkg::SUM_W'(fc4_pkg::D_WT_A[i]));
      end
   end

   // first two levels of the adder tree, four lanes per half
   always_comb begin
      for (int h = 0; h < 2; h++) begin
         part_in.a[h] = (term_ff.first[4*h]    + term_ff.first[4*h+1])
                      + (term_ff.first[4*h+2]  + term_ff.first[4*h+3]);
         part_in.b[h] = (term_ff.second[4*h]   + term_ff.second[4*h+1])
                      + (term_ff.second[4*h+2] + term_ff.second[4*h+3]);
         part_in.c[h] = (term_ff.third[4*h]    + term_ff.third[4*h+1])
                      + (term_ff.third[4*h+2]  + term_ff.third[4*h+3]);
         part_in.d[h] = (term_ff.fourth[4*h]   + term_ff.fourth[4*h+1])
                      + (term_ff.fourth[4*h+2] + term_ff.fourth[4*h+3]);
      end
   end

   // final level
   always_comb begin
      rsp_in.sum_a = part_ff.a[0] + part_ff.a[1];
      rsp_in.sum_b = part_ff.b[0] + part_ff.b[1];
      rsp_in.sum_c = part_ff.c[0] + part_ff.c[1];
      rsp_in.sum_d = part_ff.d[0] + part_ff.d[1];
   end

   // stage valid flags
   always_ff @(posedge clock) begin
      if (reset) begin
         snap_vld_ff <= 1'b0;
         term_vld_ff <= 1'b0;
         part_vld_ff <= 1'b0;
         rsp_vld_ff  <= 1'b0;
      end else begin
         if (snap_en) snap_vld_ff <= snap_valid;
         if (term_en) term_vld_ff <= snap_vld_ff;
         if (part_en) part_vld_ff <= term_vld_ff;
         if (rsp_en)  rsp_vld_ff  <= part_vld_ff;
      end
   end

   // stage payloads
   always_ff @(posedge clock) begin
      if (snap_en) snap_ff <= snap_data;
      if (term_en) term_ff <= term_in;
      if (part_en) part_ff <= part_in;
      if (rsp_en)  rsp_ff  <= rsp_in;
   end

   assign rsp_valid = rsp_vld_ff;
   assign rsp_data  = rsp_ff;

endmodule
